/* rtl/core/xibe_pkg.sv */
// Shared types and constants for the x86 instruction byte encoder.
`default_nettype none
package xibe_pkg;

   localparam int unsigned ENC_MAX_BYTES = 11;
   localparam int unsigned LEN_W         = 4;

   typedef logic [ENC_MAX_BYTES-1:0][7:0] enc_bytes_type;

   // One encoded instruction as it travels from the front end to the emitter.
   typedef struct packed {
      enc_bytes_type    bytes;
      logic [LEN_W-1:0] len;
   } enc_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [3:0] {
      CMD_NOP      = 4'd0,
      CMD_XOR      = 4'd1,
      CMD_RET      = 4'd2,
      CMD_RET_POP  = 4'd3,
      CMD_CALL     = 4'd4,
      CMD_PUSH_REG = 4'd5,
      CMD_PUSH_IMM = 4'd6,
      CMD_POP      = 4'd7,
      CMD_INC      = 4'd8,
      CMD_DEC      = 4'd9,
      CMD_MOV_RR   = 4'd10,
      CMD_MOV_RI   = 4'd11,
      CMD_STORE    = 4'd12,
      CMD_LOAD     = 4'd13,
      CMD_MEM_IMM  = 4'd14
   } cmd_type;

   localparam logic [1:0] SZ_16 = 2'd1;
   localparam logic [1:0] SZ_8  = 2'd2;

   localparam logic [2:0] REG_ESP = 3'd4;
   localparam logic [2:0] REG_EBP = 3'd5;

   localparam logic [7:0] PFX_OPSIZE  = 8'h66;
   localparam logic [7:0] OP_NOP      = 8'h90;
   localparam logic [7:0] OP_RET      = 8'hC3;
   localparam logic [7:0] OP_RET_POP  = 8'hC2;
   localparam logic [7:0] OP_PUSH_I8  = 8'h6A;
   localparam logic [7:0] OP_PUSH_I32 = 8'h68;
   localparam logic [7:0] OP_MOV_MI   = 8'hC7;
   localparam logic [7:0] OP_MOV_LOAD = 8'h8B;
   localparam logic [7:0] OP_MOV_STOR = 8'h89;
   localparam logic [7:0] OP_GRP_FE   = 8'hFE;
   localparam logic [7:0] OP_GRP_FF   = 8'hFF;
   localparam logic [7:0] SIB_ESP     = 8'h24;
   localparam logic [6:0] OP_XOR_HI   = 7'b0011001;

   // True when a 32-bit value sign-extends from its low byte.
   function automatic logic fits8(input logic [31:0] v);
      return (v[31:7] == '0) || (v[31:7] == '1);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/xibe_front.sv */
// Front end: decodes one instruction description into its byte string.
`default_nettype none
module xibe_front (
   input  wire logic [3:0]       command,
   input  wire logic [1:0]       operand_size,
   input  wire logic [2:0]       reg_a,
   input  wire logic [2:0]       reg_b,
   input  wire logic             has_offset,
   input  wire logic [31:0]      offset,
   input  wire logic [31:0]      immediate,
   input  wire logic [15:0]      pop_count,
   output xibe_pkg::enc_type     enc,
   output logic                  enc_nonempty
);
   import xibe_pkg::*;

   enc_bytes_type    b;
   logic [LEN_W-1:0] n;
   logic             sz8;
   logic             sz16;
   logic             sub;
   logic             mem_has;
   logic [31:0]      mem_disp;
   logic             mem_short;
   logic [2:0]       mem_reg;
   logic [1:0]       mem_mod;

   always_comb begin
      sz8       = (operand_size == SZ_8);
      sz16      = (operand_size == SZ_16);
      sub       = (command == CMD_DEC);
      // A plain [EBP] has no mod-00 form, so it goes out as [EBP+0].
      mem_has   = has_offset || (reg_a == REG_EBP);
      mem_disp  = has_offset ? offset : 32'd0;
      mem_short = fits8(mem_disp);
      mem_reg   = (command == CMD_MEM_IMM) ? 3'd0 : reg_b;
      mem_mod   = !mem_has ? 2'b00 : (mem_short ? 2'b01 : 2'b10);

      b = '0;
      n = '0;
      unique case (command)
         CMD_NOP: begin
            b[n] = OP_NOP; n = n + 4'd1;
         end
         CMD_XOR: begin
            if (sz16) begin
               b[n] = PFX_OPSIZE; n = n + 4'd1;
            end
            b[n] = {OP_XOR_HI, ~sz8}; n = n + 4'd1;
            b[n] = {2'b11, reg_a, reg_b}; n = n + 4'd1;
         end
         CMD_RET: begin
            b[n] = OP_RET; n = n + 4'd1;
         end
         CMD_RET_POP: begin
            b[n] = OP_RET_POP; n = n + 4'd1;
            b[n] = pop_count[7:0]; n = n + 4'd1;
            b[n] = pop_count[15:8]; n = n + 4'd1;
         end
         CMD_CALL: begin
            b[n] = OP_GRP_FF; n = n + 4'd1;
            b[n] = {5'b11010, reg_a}; n = n + 4'd1;
         end
         CMD_PUSH_REG: begin
            b[n] = {5'b01010, reg_a}; n = n + 4'd1;
         end
         CMD_PUSH_IMM: begin
            if (fits8(immediate)) begin
               b[n] = OP_PUSH_I8; n = n + 4'd1;
               b[n] = immediate[7:0]; n = n + 4'd1;
            end else begin
               b[n] = OP_PUSH_I32; n = n + 4'd1;
               b[n] = immediate[7:0]; n = n + 4'd1;
               b[n] = immediate[15:8]; n = n + 4'd1;
               b[n] = immediate[23:16]; n = n + 4'd1;
               b[n] = immediate[31:24]; n = n + 4'd1;
            end
         end
         CMD_POP: begin
            b[n] = {5'b01011, reg_a}; n = n + 4'd1;
         end
         CMD_INC, CMD_DEC: begin
            if (sz8) begin
               b[n] = OP_GRP_FE; n = n + 4'd1;
               b[n] = {2'b11, 2'b00, sub, reg_a}; n = n + 4'd1;
            end else begin
               if (sz16) begin
                  b[n] = PFX_OPSIZE; n = n + 4'd1;
               end
               b[n] = {4'b0100, sub, reg_a}; n = n + 4'd1;
            end
         end
         CMD_MOV_RR: begin
            b[n] = OP_MOV_LOAD; n = n + 4'd1;
            b[n] = {2'b11, reg_a, reg_b}; n = n + 4'd1;
         end
         CMD_MOV_RI: begin
            b[n] = {5'b10111, reg_a}; n = n + 4'd1;
            b[n] = immediate[7:0]; n = n + 4'd1;
            b[n] = immediate[15:8]; n = n + 4'd1;
            b[n] = immediate[23:16]; n = n + 4'd1;
            b[n] = immediate[31:24]; n = n + 4'd1;
         end
         CMD_STORE, CMD_LOAD, CMD_MEM_IMM: begin
            if (command == CMD_MEM_IMM) begin
               b[n] = OP_MOV_MI; n = n + 4'd1;
            end else if (command == CMD_LOAD) begin
               b[n] = OP_MOV_LOAD; n = n + 4'd1;
            end else begin
               b[n] = OP_MOV_STOR; n = n + 4'd1;
            end
            b[n] = {mem_mod, mem_reg, reg_a}; n = n + 4'd1;
            if (reg_a == REG_ESP) begin
               b[n] = SIB_ESP; n = n + 4'd1;
            end
            if (mem_has) begin
               b[n] = mem_disp[7:0]; n = n + 4'd1;
               if (!mem_short) begin
                  b[n] = mem_disp[15:8]; n = n + 4'd1;
                  b[n] = mem_disp[23:16]; n = n + 4'd1;
                  b[n] = mem_disp[31:24]; n = n + 4'd1;
               end
            end
            if (command == CMD_MEM_IMM) begin
               b[n] = immediate[7:0]; n = n + 4'd1;
               b[n] = immediate[15:8]; n = n + 4'd1;
               b[n] = immediate[23:16]; n = n + 4'd1;
               b[n] = immediate[31:24]; n = n + 4'd1;
            end
         end
         default: begin
            // Unassigned command: nothing is emitted.
         end
      endcase

      enc.bytes    = b;
      enc.len      = n;
      enc_nonempty = (n != '0);
   end

endmodule
`default_nettype wire

/* rtl/core/xibe_queue.sv */
// Two-entry queue of encoded instructions between front end and emitter.
`default_nettype none
module xibe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire xibe_pkg::enc_type push_data,
   input  wire logic              pop,
   output xibe_pkg::enc_type      head,
   output xibe_pkg::q_stat_type   stat
);
   import xibe_pkg::*;

   enc_type    head_ff;
   enc_type    head_in;
   enc_type    tail_ff;
   enc_type    tail_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = tail_ff;
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head       = head_ff;
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

endmodule
`default_nettype wire

/* rtl/core/xibe_back.sv */
// Back end: shifts one encoded instruction out a byte per word.
`default_nettype none
module xibe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire xibe_pkg::enc_type    head,
   input  wire xibe_pkg::q_stat_type stat,
   output logic                      pop,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [7:0]                out_byte,
   output logic [3:0]                out_index,
   output logic                      out_last
);
   import xibe_pkg::*;

   enc_bytes_type    bytes_ff;
   enc_bytes_type    bytes_in;
   logic [LEN_W-1:0] left_ff;
   logic [LEN_W-1:0] left_in;
   logic [3:0]       index_ff;
   logic [3:0]       index_in;
   logic             valid_ff;
   logic             valid_in;
   logic             take;
   logic             free;

   always_comb begin
      take     = valid_ff && out_ready;
      free     = !valid_ff || (take && (left_ff == 4'd1));
      pop      = free && !stat.empty;
      bytes_in = bytes_ff;
      left_in  = left_ff;
      index_in = index_ff;
      valid_in = valid_ff;
      if (free) begin
         valid_in = !stat.empty;
         bytes_in = head.bytes;
         left_in  = head.len;
         index_in = 4'd0;
      end else if (take) begin
         bytes_in = bytes_ff >> 8;
         left_in  = left_ff - 4'd1;
         index_in = index_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      left_ff  <= left_in;
      index_ff <= index_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = bytes_ff[0];
   assign out_index = index_ff;
   assign out_last  = (left_ff == 4'd1);

endmodule
`default_nettype wire

/* rtl/core/x86_instruction_byte_encoder.sv */
// Top level of the x86 instruction byte encoder.
// The first byte of an instruction appears once its word has passed the queue head register
// and, when the emitter is free, the emitter register. Throughput: one output word per cycle
// while rsp_tready is high, for instructions of 1 to 11 bytes; the single byte-wide port sets it.
// The request side accepts one word per cycle while the two-entry queue has room.
// Reset (synchronous, active high) empties the queue and the emitter; no word is pending after.
`default_nettype none
module x86_instruction_byte_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // From bit 0: command[3:0], operand_size[5:4], reg_a[8:6], reg_b[11:9],
   // has_offset[12], offset[44:13], immediate[76:45], pop_count[92:77], zero pad.
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // From bit 0: code_byte[7:0], byte_index[11:8], zero pad.
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import xibe_pkg::*;

   enc_type    enc;
   logic       enc_nonempty;
   enc_type    q_head;
   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;
   logic [7:0] out_byte;
   logic [3:0] out_index;

   // The front end is purely combinational: a request word is decoded in the
   // cycle it is accepted and written straight into the queue.
   xibe_front u_front (
      .command      (req_tdata[3:0]),
      .operand_size (req_tdata[5:4]),
      .reg_a        (req_tdata[8:6]),
      .reg_b        (req_tdata[11:9]),
      .has_offset   (req_tdata[12]),
      .offset       (req_tdata[44:13]),
      .immediate    (req_tdata[76:45]),
      .pop_count    (req_tdata[92:77]),
      .enc          (enc),
      .enc_nonempty (enc_nonempty)
   );

   // Readiness depends only on queue occupancy, never on the output side,
   // so the two handshakes are fully decoupled. An unassigned command is
   // accepted and dropped since it encodes to no bytes.
   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && req_tready && enc_nonempty;

   xibe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (enc),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // The emitter reloads from the queue in the same cycle its last byte is
   // taken, so consecutive instructions stream without a gap.
   xibe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .stat      (q_stat),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (out_byte),
      .out_index (out_index),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, out_index, out_byte};

endmodule
`default_nettype wire

/* rtl/core/xibe_checker.sv */
// Port-level checker for the encoder output stream, with its bind.
`default_nettype none
module xibe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // A stalled word holds its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output word changed");

   // Within an instruction the next byte follows at once with the next index.
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[11:8] == $past(rsp_tdata[11:8]) + 4'd1))
      else $error("byte index did not advance within an instruction");

   // An instruction that follows straight after the last byte of another starts at index zero.
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || (rsp_tdata[11:8] == 4'd0))
      else $error("instruction did not start at byte zero");

   // No instruction is longer than eleven bytes.
   a_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:8] == 4'd10) |-> rsp_tlast)
      else $error("instruction longer than eleven bytes");

endmodule

bind x86_instruction_byte_encoder xibe_checker u_xibe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
